/* design/sgm_pkg.sv */
// Shared types, constants and helpers for the sinogram gap-mask block.
// No dependencies; every other design file but sgm_ram imports this package.
package sgm_pkg;

    localparam int PLANE_CAPACITY = 65536;
    localparam int MAX_PLANES     = 4096;

    localparam int ADDR_W   = $clog2(PLANE_CAPACITY);
    localparam int SIZE_W   = $clog2(PLANE_CAPACITY + 1);
    localparam int PLANE_W  = 12;
    localparam int POS_W    = 16;
    localparam int PCNT_W   = 13;
    localparam int DIM_W    = 11;
    localparam int DATA_W   = 32;
    localparam int ENTRY_W  = DATA_W + 2;

    localparam int RQ_DEPTH = 8;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef enum logic [1:0] {
        REG_PLANE_COUNT = 2'd0,
        REG_VIEW_COUNT  = 2'd1,
        REG_PROJ_COUNT  = 2'd2,
        REG_GAP_FILL    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PCNT_W-1:0]        plane_count;
        logic [DIM_W-1:0]         view_count;
        logic [DIM_W-1:0]         proj_count;
        logic signed [DATA_W-1:0] gap_fill;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pos;
        logic [PLANE_W-1:0] plane;
        logic               is_last;
    } seq_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     cur_mz;
        logic [ADDR_W-1:0]        pos;
        logic [PLANE_W-1:0]       plane;
        logic                     is_last;
    } s1_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [PLANE_W-1:0]       plane;
        logic [POS_W-1:0]         pos;
        logic                     last;
    } result_t;

    // Replace a positive element by the fill value when it and both neighbours are gaps.
    function automatic logic [DATA_W-1:0] gap_decide(
        input logic [DATA_W-1:0] value,
        input logic              own_mz,
        input logic              down_mz,
        input logic              up_mz,
        input logic [DATA_W-1:0] fill
    );
        logic positive;
        positive = (value != '0) && !value[DATA_W-1];
        if (positive && own_mz && down_mz && up_mz) begin
            return fill;
        end
        return value;
    endfunction

endpackage

/* design/sinogram_gap_mask_apply.sv */
// Sinogram gap-mask insertion, one element accepted per cycle while the result queue has room.
// Flow: the plane-store entry is read at acceptance; stage 1 then decides and writes back,
// and its results enter the result queue, whose head drives the output.
// Throughput: one item per cycle while the result queue has room, bounded by the single
// read and write port of the plane store; on the last plane each item gives two results
// (one when there is only one plane), so the output sets the pace.
// Reset: synchronous, active low; clears counters, pipeline and queue; the plane store is not cleared.
module sinogram_gap_mask_apply (
    input  logic                      aclk,
    input  logic                      aresetn,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [31:0]        s_sample_value,
    input  logic signed [31:0]        s_mask_value,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [31:0]        m_out_value,
    output logic [11:0]               m_out_plane,
    output logic [15:0]               m_out_position,
    output logic                      m_run_last,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import sgm_pkg::*;

    cfg_t                cfg;
    seq_t                seq;
    logic                s_accept;

    // Stage 1 holds the item whose plane-store entry is being read.
    logic                s1_valid_reg;
    s1_item_t            s1_reg;
    logic                fwd_reg;
    logic [ENTRY_W-1:0]  wdata_hold_reg;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [ENTRY_W-1:0]  entry;
    logic [ENTRY_W-1:0]  ram_wdata;

    logic                has_prev, has_cur;
    result_t             res_prev, res_cur;
    logic                push_a, push_b;
    result_t             data_a, data_b;
    result_t             head;
    logic [RQ_CNT_W-1:0] q_count;
    logic [RQ_CNT_W:0]   q_commit;

    sgm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sgm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (s_accept),
        .seq     (seq)
    );

    // Accept only while the queue can take the worst case from both the item
    // in stage 1 and the new one (two results each).
    assign q_commit = {1'b0, q_count} + (s1_valid_reg ? (RQ_CNT_W+1)'(2) : '0);
    assign s_ready  = (q_commit <= (RQ_CNT_W+1)'(RQ_DEPTH - 2));
    assign s_accept = s_valid && s_ready;

    sgm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PLANE_CAPACITY)
    ) u_plane_store (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_reg.pos),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (seq.pos),
        .rdata (ram_rdata)
    );

    // Advance stage 1; note when the entry being read is the one written this cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            fwd_reg      <= s_accept && s1_valid_reg && (s1_reg.pos == seq.pos);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg.value   <= s_sample_value;
            s1_reg.cur_mz  <= (s_mask_value == '0);
            s1_reg.pos     <= seq.pos;
            s1_reg.plane   <= seq.plane;
            s1_reg.is_last <= seq.is_last;
        end
        if (s1_valid_reg) begin
            wdata_hold_reg <= ram_wdata;
        end
    end

    // Take the entry from the store, or the write-back just made to the same place.
    assign entry = fwd_reg ? wdata_hold_reg : ram_rdata;

    always_comb begin
        has_prev = (s1_reg.plane != '0);
        has_cur  = s1_reg.is_last;

        // Entry layout: older mask-zero, previous mask-zero, previous value.
        ram_wdata = {has_prev && entry[DATA_W], s1_reg.cur_mz, s1_reg.value};

        // Element of the plane below, now that the mask above is known.
        res_prev.value = gap_decide(entry[DATA_W-1:0], entry[DATA_W],
                                    (s1_reg.plane == PLANE_W'(1)) ? 1'b1 : entry[DATA_W+1],
                                    s1_reg.cur_mz, cfg.gap_fill);
        res_prev.plane = s1_reg.plane - PLANE_W'(1);
        res_prev.pos   = POS_W'(s1_reg.pos);
        res_prev.last  = !s1_reg.is_last;

        // Element of the last plane, with nothing above it.
        res_cur.value = gap_decide(s1_reg.value, s1_reg.cur_mz,
                                   has_prev ? entry[DATA_W] : 1'b1,
                                   1'b1, cfg.gap_fill);
        res_cur.plane = s1_reg.plane;
        res_cur.pos   = POS_W'(s1_reg.pos);
        res_cur.last  = 1'b1;

        // Pack results so the earlier one always takes the first slot.
        push_a = s1_valid_reg && (has_prev || has_cur);
        data_a = has_prev ? res_prev : res_cur;
        push_b = s1_valid_reg && has_prev && has_cur;
        data_b = res_cur;
    end

    sgm_result_fifo u_results (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (push_a),
        .data_a    (data_a),
        .push_b    (push_b),
        .data_b    (data_b),
        .pop       (m_ready),
        .not_empty (m_valid),
        .head      (head),
        .count     (q_count)
    );

    assign m_out_value    = head.value;
    assign m_out_plane    = head.plane;
    assign m_out_position = head.pos;
    assign m_run_last     = head.last;

endmodule

/* design/sgm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; a read of the address being written returns the old contents.
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/sgm_cfg_regs.sv */
// APB-style configuration registers: plane, view and projection counts and fill value.
// Depends on sgm_pkg.
module sgm_cfg_regs (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output sgm_pkg::cfg_t cfg
);
    import sgm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.plane_count <= PCNT_W'(1);
            cfg_reg.view_count  <= DIM_W'(1);
            cfg_reg.proj_count  <= DIM_W'(1);
            cfg_reg.gap_fill    <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PLANE_COUNT: cfg_reg.plane_count <= pwdata[PCNT_W-1:0];
                REG_VIEW_COUNT:  cfg_reg.view_count  <= pwdata[DIM_W-1:0];
                REG_PROJ_COUNT:  cfg_reg.proj_count  <= pwdata[DIM_W-1:0];
                REG_GAP_FILL:    cfg_reg.gap_fill    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PLANE_COUNT: prdata = {{(32-PCNT_W){1'b0}}, cfg_reg.plane_count};
            REG_VIEW_COUNT:  prdata = {{(32-DIM_W){1'b0}}, cfg_reg.view_count};
            REG_PROJ_COUNT:  prdata = {{(32-DIM_W){1'b0}}, cfg_reg.proj_count};
            REG_GAP_FILL:    prdata = cfg_reg.gap_fill;
            default:         prdata = '0;
        endcase
    end

endmodule

/* design/sgm_seq.sv */
// Position and plane counters: clamp the sizes, give each accepted item its place.
// Depends on sgm_pkg.
module sgm_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  sgm_pkg::cfg_t cfg,
    input  logic          advance,
    output sgm_pkg::seq_t seq
);
    import sgm_pkg::*;

    logic [ADDR_W-1:0]    pos_reg,   pos_next;
    logic [PLANE_W-1:0]   plane_reg, plane_next;
    logic [PCNT_W-1:0]    planes;
    logic [DIM_W-1:0]     views, projs;
    logic [2*DIM_W-1:0]   prod;
    logic [SIZE_W-1:0]    size;
    logic [ADDR_W-1:0]    pos_eff;
    logic [PLANE_W-1:0]   plane_eff;
    logic                 is_last;
    logic                 wrap;

    always_comb begin
        views = (cfg.view_count == '0) ? DIM_W'(1) : cfg.view_count;
        projs = (cfg.proj_count == '0) ? DIM_W'(1) : cfg.proj_count;
        prod  = views * projs;
        if (prod > (2*DIM_W)'(PLANE_CAPACITY)) begin
            size = SIZE_W'(PLANE_CAPACITY);
        end else begin
            size = prod[SIZE_W-1:0];
        end

        if (cfg.plane_count == '0) begin
            planes = PCNT_W'(1);
        end else if (cfg.plane_count > PCNT_W'(MAX_PLANES)) begin
            planes = PCNT_W'(MAX_PLANES);
        end else begin
            planes = cfg.plane_count;
        end

        // Restart a counter left beyond a freshly written limit.
        pos_eff   = ({1'b0, pos_reg} >= size) ? '0 : pos_reg;
        plane_eff = ({1'b0, plane_reg} >= planes) ? '0 : plane_reg;
        is_last   = ({1'b0, plane_eff} + PCNT_W'(1)) >= planes;
        wrap      = ({1'b0, pos_eff} + SIZE_W'(1)) >= size;

        pos_next   = pos_reg;
        plane_next = plane_reg;
        if (advance) begin
            if (wrap) begin
                pos_next   = '0;
                plane_next = is_last ? '0 : plane_eff + PLANE_W'(1);
            end else begin
                pos_next   = pos_eff + ADDR_W'(1);
                plane_next = plane_eff;
            end
        end

        seq.pos     = pos_eff;
        seq.plane   = plane_eff;
        seq.is_last = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            plane_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            plane_reg <= plane_next;
        end
    end

endmodule

/* design/sgm_result_fifo.sv */
// Result queue: takes up to two results a cycle, hands one out per handshake.
// Depends on sgm_pkg.
module sgm_result_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push_a,
    input  sgm_pkg::result_t              data_a,
    input  logic                          push_b,
    input  sgm_pkg::result_t              data_b,
    input  logic                          pop,
    output logic                          not_empty,
    output sgm_pkg::result_t              head,
    output logic [sgm_pkg::RQ_CNT_W-1:0]  count
);
    import sgm_pkg::*;

    result_t             slot_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0] cnt_reg,    cnt_next;
    logic [RQ_CNT_W-1:0] n_push;
    logic                do_pop;

    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign do_pop    = pop && not_empty;

    always_comb begin
        n_push      = RQ_CNT_W'(push_a) + RQ_CNT_W'(push_b);
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(do_pop);
        cnt_next    = cnt_reg + n_push - RQ_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Second result of a pair lands in the slot after the first.
    always_ff @(posedge aclk) begin
        if (push_a) begin
            slot_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b) begin
            slot_reg[wr_ptr_reg + RQ_PTR_W'(1)] <= data_b;
        end
    end

endmodule

/* tb/sv/sinogram_gap_mask_apply_tb.sv */
// Self-checking testbench for the sinogram gap-mask block: directed gap cases,
// size limits, counter restarts and random volumes, checked against a local predictor.
// Depends on sgm_pkg and the sinogram_gap_mask_apply top level.
module sinogram_gap_mask_apply_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sgm_pkg::*;

    localparam int RANDOM_ITEMS = 560;  // rough size of the random phase
    localparam int QUIET_CYCLES = 8;    // covers the pipeline plus the result queue
    localparam int MAX_REPORTS  = 40;   // keep the log short if the block is badly broken

    // ------------------------------------------------------------------
    // Clock, block ports and instance
    // ------------------------------------------------------------------
    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_sample_value = '0;
    logic signed [31:0] s_mask_value   = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [31:0] m_out_value;
    logic [11:0]        m_out_plane;
    logic [15:0]        m_out_position;
    logic               m_run_last;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [3:0]         paddr          = '0;
    logic [31:0]        pwdata         = '0;
    logic [31:0]        prdata;
    logic               pready;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sinogram_gap_mask_apply i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .s_mask_value   (s_mask_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_plane    (m_out_plane),
        .m_out_position (m_out_position),
        .m_run_last     (m_run_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Run bookkeeping
    // ------------------------------------------------------------------
    int unsigned error_count     = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned register_writes = 0;
    int unsigned burst_left      = 0;

    // Output elements still owed by the block, oldest first.
    result_t awaited_elems[$];

    // ------------------------------------------------------------------
    // Predictor: own copy of the configuration, the plane buffer and the
    // position and plane counters.
    // ------------------------------------------------------------------
    logic [PCNT_W-1:0] cfg_planes = 13'd1;
    logic [DIM_W-1:0]  cfg_views  = 11'd1;
    logic [DIM_W-1:0]  cfg_projs  = 11'd1;
    logic [31:0]       cfg_fill   = '0;

    logic [31:0] held_value   [PLANE_CAPACITY];
    bit          held_gap     [PLANE_CAPACITY];
    bit          held_old_gap [PLANE_CAPACITY];

    int unsigned at_pos   = 0;
    int unsigned at_plane = 0;

    // Zero acts as one plane; clamp to the plane limit.
    function automatic int unsigned active_planes();
        int unsigned planes;
        planes = (cfg_planes == 0) ? 1 : cfg_planes;
        return (planes > MAX_PLANES) ? MAX_PLANES : planes;
    endfunction

    // Zero dimensions act as one; clamp the plane to the buffer capacity.
    function automatic int unsigned active_size();
        int unsigned views;
        int unsigned projs;
        int unsigned size;
        views = (cfg_views == 0) ? 1 : cfg_views;
        projs = (cfg_projs == 0) ? 1 : cfg_projs;
        size  = views * projs;
        return (size > PLANE_CAPACITY) ? PLANE_CAPACITY : size;
    endfunction

    // Sizes may only change here, or the block could read buffer entries never written.
    function automatic bit volume_boundary();
        return (at_pos == 0) && (at_plane == 0);
    endfunction

    function automatic logic [31:0] fill_or_keep(input logic [31:0] value, input bit own_gap,
                                                 input bit below_gap, input bit above_gap);
        if (value != 0 && !value[31] && own_gap && below_gap && above_gap) begin
            return cfg_fill;
        end
        return value;
    endfunction

    // Work out the elements released by one accepted item and queue them.
    task automatic compute_gap_insert(input logic [31:0] sample, input logic [31:0] mask);
        int unsigned planes;
        int unsigned size;
        int unsigned pos;
        int unsigned plane;
        bit          cur_gap;
        bit          last_plane;
        logic [31:0] prev_value;
        bit          prev_gap;
        bit          older_gap;
        result_t     elem;
        planes = active_planes();
        size   = active_size();
        // Restart counters that a register write has left beyond the new limits.
        if (at_pos >= size) at_pos = 0;
        if (at_plane >= planes) at_plane = 0;
        pos        = at_pos;
        plane      = at_plane;
        cur_gap    = (mask == 0);
        last_plane = (plane + 1 >= planes);
        prev_value = held_value[pos];
        prev_gap   = held_gap[pos];
        older_gap  = held_old_gap[pos];

        // Release the element of the plane below, now that its upper neighbour is known.
        if (plane > 0) begin
            elem.value = fill_or_keep(prev_value, prev_gap, (plane == 1) ? 1'b1 : older_gap,
                                      cur_gap);
            elem.plane = 12'(plane - 1);
            elem.pos   = 16'(pos);
            elem.last  = !last_plane;
            awaited_elems.push_back(elem);
        end

        held_value[pos]   = sample;
        held_gap[pos]     = cur_gap;
        held_old_gap[pos] = (plane > 0) && prev_gap;

        // On the top plane the element itself goes out too, with nothing above it.
        if (last_plane) begin
            elem.value = fill_or_keep(sample, cur_gap, (plane == 0) ? 1'b1 : prev_gap, 1'b1);
            elem.plane = 12'(plane);
            elem.pos   = 16'(pos);
            elem.last  = 1'b1;
            awaited_elems.push_back(elem);
        end

        if (pos + 1 >= size) begin
            at_pos   = 0;
            at_plane = last_plane ? 0 : ((plane + 1) & 12'hFFF);
        end else begin
            at_pos = (pos + 1) & 16'hFFFF;
        end
    endtask

    task automatic apply_register(input reg_idx_t idx, input logic [31:0] data);
        case (idx)
            REG_PLANE_COUNT: cfg_planes = data[PCNT_W-1:0];
            REG_VIEW_COUNT:  cfg_views  = data[DIM_W-1:0];
            REG_PROJ_COUNT:  cfg_projs  = data[DIM_W-1:0];
            REG_GAP_FILL:    cfg_fill   = data;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Failure reporting
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end else if (error_count == MAX_REPORTS + 1) begin
            $display("%0t ns: further failures counted but not shown", $time);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern picked anew whenever the low byte of the cycle count
    // wraps, and check each accepted element against the oldest one awaited.
    // ------------------------------------------------------------------
    logic [15:0] rx_cycle = '0;
    logic [1:0]  rx_mode  = '0;

    always @(negedge aclk) begin
        bit ready_next;
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[7:0] == 8'd0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0:    ready_next = 1'b1;
            2'd1:    ready_next = ($urandom_range(0, 9) < 6);
            2'd2:    ready_next = (rx_cycle[2:0] > 3'd2);
            default: ready_next = rx_cycle[5] | ($urandom_range(0, 1) == 1);
        endcase
        m_ready <= ready_next;
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_elems.size() == 0) begin
                note_failure($sformatf({"unexpected element, expected none, ",
                                        "actual value %h plane %0d pos %0d last %0b"},
                                       m_out_value, m_out_plane, m_out_position,
                                       m_run_last));
            end else begin
                want = awaited_elems.pop_front();
                results_checked++;
                if (m_out_value !== want.value) begin
                    note_failure($sformatf("out_value expected %h actual %h", want.value,
                                           m_out_value));
                end
                if (m_out_plane !== want.plane) begin
                    note_failure($sformatf("out_plane expected %0d actual %0d", want.plane,
                                           m_out_plane));
                end
                if (m_out_position !== want.pos) begin
                    note_failure($sformatf("out_position expected %0d actual %0d", want.pos,
                                           m_out_position));
                end
                if (m_run_last !== want.last) begin
                    note_failure($sformatf("run_last expected %0b actual %0b", want.last,
                                           m_run_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Work in bursts; between bursts drop valid and scramble the payload.
    task automatic pace_input();
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid        <= 1'b0;
                s_sample_value <= $urandom;
                s_mask_value   <= $urandom;
            end
            // Now and then a long stretch with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Present one item, hold it until accepted, then predict its results.
    task automatic send_element(input logic [31:0] sample, input logic [31:0] mask);
        pace_input();
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_sample_value <= sample;
        s_mask_value   <= mask;
        do @(posedge aclk); while (!s_ready);
        compute_gap_insert(sample, mask);
        items_sent++;
    endtask

    // Drop valid and wait for every awaited element; optionally let the pipeline settle
    // too, since plane-0 items below the last plane leave nothing in the queue while still in flight.
    task automatic drain_results(input bit settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_elems.size() != 0) @(posedge aclk);
        if (settle) begin
            repeat (QUIET_CYCLES) @(posedge aclk);
        end
    endtask

    // Setup cycle, access cycle, write on the edge with pready high.
    task automatic write_register(input reg_idx_t idx, input logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        apply_register(idx, data);
        register_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(1, 32'h7FFF_FFFF);
            2:       return $urandom_range(1, 32'h0003_0000);
            3:       return {1'b1, 31'($urandom)};
            4:       return 32'd0;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Density 0 gives mostly non-zero masks, 4 gives all gaps.
    function automatic logic [31:0] random_mask(input int unsigned density);
        if ($urandom_range(0, 3) < density) begin
            return 32'd0;
        end
        case ($urandom_range(0, 3))
            0:       return 32'h0001_0000;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic reset_block();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: one element per volume, so each item answers at once with nothing
    // above or below it; check sign, zero and mask extremes.
    task automatic test_reset_defaults();
        logic [31:0] samples [9] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                                     32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                     32'h0001_0000, 32'h7FFF_FFFF, 32'h1234_5678};
        logic [31:0] masks   [9] = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                     32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < 9; i++) begin
            send_element(samples[i], masks[i]);
        end
        drain_results(1'b1);
    endtask

    // Zero in every size register must act as one.
    task automatic test_zero_sizes();
        write_register(REG_PLANE_COUNT, 32'd0);
        write_register(REG_VIEW_COUNT, 32'd0);
        write_register(REG_PROJ_COUNT, 32'd0);
        write_register(REG_GAP_FILL, 32'h7FFF_FFFF);
        send_element(32'h0000_0100, 32'h0);
        send_element(32'h0000_0100, 32'h1);
        send_element(32'hFFFF_0000, 32'h0);
        drain_results(1'b1);
    endtask

    // Three planes of 2 x 2: positions cover a gap column, a gap broken above,
    // a gap broken below and a gap only on the outer planes.
    task automatic test_three_plane_volume();
        logic [31:0] samples [12] = '{32'h0002_0000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h0000_0001,
                                      32'h8000_0001, 32'h0001_0000, 32'h0003_0000, 32'h0000_0002,
                                      32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 32'h7FFF_FFFF};
        logic [31:0] masks   [12] = '{32'h0, 32'h0, 32'h1, 32'h0,
                                      32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                                      32'h0, 32'h0, 32'h0, 32'h8000_0000};
        write_register(REG_PLANE_COUNT, 32'd3);
        write_register(REG_VIEW_COUNT, 32'd2);
        write_register(REG_PROJ_COUNT, 32'd2);
        write_register(REG_GAP_FILL, 32'h8000_0000);
        for (int i = 0; i < 12; i++) begin
            send_element(samples[i], masks[i]);
        end
        drain_results(1'b1);
    endtask

    // Settle the block, then change settings; sizes only at a volume boundary.
    task automatic pick_random_setting();
        logic [31:0] fill;
        drain_results(1'b1);
        if (volume_boundary()) begin
            write_register(REG_VIEW_COUNT,
                           ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 3));
            write_register(REG_PROJ_COUNT,
                           ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 4));
        end
        if ($urandom_range(0, 3) != 0) begin
            write_register(REG_PLANE_COUNT, $urandom_range(0, 5));
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       fill = 32'h8000_0000;
                1:       fill = 32'h7FFF_FFFF;
                2:       fill = 32'd0;
                default: fill = $urandom;
            endcase
            write_register(REG_GAP_FILL, fill);
        end
    endtask

    // Mostly whole volumes with random content; some cut short, after which only the
    // plane count and fill may change. Stop only at a volume boundary.
    task automatic test_random_volumes();
        int unsigned sent_here;
        int unsigned remaining;
        int unsigned planes;
        int unsigned size;
        int unsigned eff_pos;
        int unsigned eff_plane;
        int unsigned density;
        sent_here = 0;
        while (sent_here < RANDOM_ITEMS || !volume_boundary()) begin
            pick_random_setting();
            planes    = active_planes();
            size      = active_size();
            eff_pos   = (at_pos >= size) ? 0 : at_pos;
            eff_plane = (at_plane >= planes) ? 0 : at_plane;
            remaining = (planes - eff_plane) * size - eff_pos;
            if ($urandom_range(0, 7) == 0) begin
                remaining = $urandom_range(1, remaining);
            end
            density = $urandom_range(0, 4);
            repeat (remaining) begin
                // Hold off now and then until the block has caught up.
                if ($urandom_range(0, 99) == 0) begin
                    drain_results(1'b0);
                end
                send_element(random_sample(), random_mask(density));
            end
            sent_here += remaining;
        end
        drain_results(1'b1);
    endtask

    // A plane count above the limit acts as the limit: run a stretch of one-element
    // planes, then shrink the plane count under the plane counter to force a restart
    // and close a short volume.
    task automatic test_plane_limit();
        write_register(REG_PLANE_COUNT, 32'h0000_1FFF);
        write_register(REG_VIEW_COUNT, 32'd1);
        write_register(REG_PROJ_COUNT, 32'd1);
        write_register(REG_GAP_FILL, $urandom);
        repeat (40) begin
            send_element(random_sample(), random_mask(3));
        end
        drain_results(1'b1);
        // Plane counter now 40: beyond the new limit.
        write_register(REG_PLANE_COUNT, 32'd3);
        repeat (3) begin
            send_element(random_sample(), random_mask(3));
        end
        drain_results(1'b1);
    endtask

    // A 2047 x 2047 plane clamps to the buffer capacity, so position 3 is still
    // inside plane 0. Then shrink the plane under the position counter to force a restart.
    task automatic test_oversize_plane_and_restart();
        write_register(REG_PLANE_COUNT, 32'd2);
        write_register(REG_VIEW_COUNT, 32'd2047);
        write_register(REG_PROJ_COUNT, 32'd2047);
        write_register(REG_GAP_FILL, $urandom);
        repeat (3) begin
            send_element(random_sample(), random_mask(3));
        end
        drain_results(1'b1);
        // Position now 3: beyond the new plane size.
        write_register(REG_PLANE_COUNT, 32'd1);
        write_register(REG_VIEW_COUNT, 32'd1);
        write_register(REG_PROJ_COUNT, 32'd2);
        repeat (4) begin
            send_element(random_sample(), random_mask(2));
        end
        drain_results(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_block();
        test_reset_defaults();
        test_zero_sizes();
        test_three_plane_volume();
        test_random_volumes();
        test_plane_limit();
        test_oversize_plane_and_restart();
        drain_results(1'b1);
        $display("Run covered %0d items, %0d checked elements and %0d register writes.",
                 items_sent, results_checked, register_writes);
        $display({"Scope: directed gap cases, zero and oversize sizes, plane limit, ",
                  "counter restarts, random volumes."});
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #8_000_000;
        $display("%0t ns: timeout with %0d elements still awaited", $time, awaited_elems.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
